// ===== rtl/neighbor_cache_lru_macros.svh =====
// assertion macros for the neighbor cache rtl
// no dependencies; included by modules that assert
`ifndef NEIGHBOR_CACHE_LRU_MACROS_SVH
`define NEIGHBOR_CACHE_LRU_MACROS_SVH
`ifndef SYNTHESIS
`define NCL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NCL_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCL_ASSERT(label, clk, rst, prop, msg)
`define NCL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ncl_pkg.sv =====
// shared types and constants for the neighbor cache
// no dependencies
package ncl_pkg;
   localparam int DEFAULT_ENTRIES = 16;
   localparam int KEY_W = 64;
   localparam int MAC_W = 48;
   localparam int TIME_W = 64;
   localparam int IDX_OUT_W = 4;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MATCH, ST_SCAN, ST_WRITE, ST_OUT
   } state_type;

   // request broadcast down the cell row
   typedef struct packed {
      logic              func;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] now;
   } request_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic              hit;      // match seen at a lower index
      logic              free;     // free entry seen at a lower index
      logic              old;      // entry older than now seen
      logic [TIME_W-1:0] oldest;
      logic [5:0]        slot;
   } token_type;
endpackage

// ===== rtl/neighbor_cache_lru.sv =====
// neighbor cache, fully associative with timestamp lru, a row of entry cells
// one item at a time: a new item is accepted only when idle, after the previous response is taken;
// the scan token moves one cell per cycle across the row, then the selected cell is written
// reset clears all valid bits and the enable at once; no clearing pass
// depends on ncl_pkg, ncl_cell and neighbor_cache_lru_macros.svh
`include "neighbor_cache_lru_macros.svh"
module neighbor_cache_lru #(
   parameter int ENTRIES = ncl_pkg::DEFAULT_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data,    // enable
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [239:0] req_tdata,   // address_high, address_low, mac_in, current_time
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata    // found, mac_out, entry_index, written, pad
);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(ENTRIES - 2);

   ncl_pkg::state_type state_ff, state_in;
   ncl_pkg::request_type req_ff;
   logic enable_ff;
   ncl_pkg::token_type tok [ENTRIES+1];
   logic [ENTRIES-1:0] match;
   logic [ncl_pkg::MAC_W-1:0] macs [ENTRIES];
   logic [ENTRIES-1:0] wr_key, wr_mac, wr_time;
   logic hit_ff;
   logic [IDX_W-1:0] hit_idx_ff, sel_idx;
   logic hit_any;
   logic [IDX_W-1:0] hit_idx;
   logic [ncl_pkg::MAC_W-1:0] hit_mac_ff;
   logic [ncl_pkg::MAC_W-1:0] rsp_mac;
   logic [IDX_W-1:0] scan_cnt_ff;
   logic [55:0] rsp_ff;
   logic do_write;

   assign csr_ready  = 1'b1;
   assign req_tready = state_ff == ncl_pkg::ST_IDLE;
   assign rsp_tvalid = state_ff == ncl_pkg::ST_OUT;
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) enable_ff <= 1'b0;
      else if (csr_valid) enable_ff <= csr_data;
   end

   // capture request
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.func     <= req_tuser;
         req_ff.key_high <= req_tdata[63:0];
         req_ff.key_low  <= req_tdata[127:64];
         req_ff.mac      <= req_tdata[175:128];
         req_ff.now      <= req_tdata[239:176];
      end
   end

   // token head and cell row
   assign tok[0] = '{hit: 1'b0, free: 1'b0, old: 1'b0, oldest: req_ff.now, slot: '0};
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ncl_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(i))) u_cell (
         .clock(clock), .reset(reset), .req(req_ff),
         .tok_in(tok[i]), .tok_out(tok[i+1]),
         .match(match[i]), .mac(macs[i]),
         .wr_key(wr_key[i]), .wr_mac(wr_mac[i]), .wr_time(wr_time[i])
      );
   end

   // priority encode of the match vector
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ncl_pkg::ST_MATCH) begin
         hit_ff     <= hit_any;
         hit_idx_ff <= hit_idx;
         hit_mac_ff <= macs[hit_idx];
      end
   end

   // cycles spent while the token walks the row
   always_ff @(posedge clock) begin
      if (state_ff == ncl_pkg::ST_SCAN) scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
      else scan_cnt_ff <= '0;
   end

   assign sel_idx  = hit_ff ? hit_idx_ff : tok[ENTRIES].slot[IDX_W-1:0];
   assign do_write = state_ff == ncl_pkg::ST_WRITE && enable_ff &&
                     (hit_ff || req_ff.func == ncl_pkg::FUNC_UPDATE);

   // write strobes into the row
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         wr_time[i] = do_write && sel_idx == IDX_W'(i);
         wr_mac[i]  = wr_time[i] && req_ff.func == ncl_pkg::FUNC_UPDATE;
         wr_key[i]  = wr_time[i] && !hit_ff;
      end
   end

   // response
   assign rsp_mac = (hit_ff && req_ff.func == ncl_pkg::FUNC_LOOKUP) ? hit_mac_ff : '0;

   always_ff @(posedge clock) begin
      if (state_ff == ncl_pkg::ST_WRITE) begin
         if (do_write) begin
            rsp_ff <= {2'b00, 1'b1,
                       ncl_pkg::IDX_OUT_W'({{ncl_pkg::IDX_OUT_W{1'b0}}, sel_idx}),
                       rsp_mac, hit_ff};
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ncl_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ncl_pkg::ST_IDLE:  if (req_tvalid) state_in = ncl_pkg::ST_MATCH;
         ncl_pkg::ST_MATCH: state_in = ncl_pkg::ST_SCAN;
         ncl_pkg::ST_SCAN:  if (scan_cnt_ff == SCAN_LAST) state_in = ncl_pkg::ST_WRITE;
         ncl_pkg::ST_WRITE: state_in = ncl_pkg::ST_OUT;
         ncl_pkg::ST_OUT:   if (rsp_tready) state_in = ncl_pkg::ST_IDLE;
         default:           state_in = ncl_pkg::ST_IDLE;
      endcase
   end

   `NCL_ASSERT(a_one_write, clock, reset, $countones(wr_time) <= 1, "more than one entry written")
   `NCL_ASSERT(a_rsp_written, clock, reset, rsp_tvalid && !rsp_tdata[53] |-> rsp_tdata[52:0] == '0, "miss carries data")
   `NCL_ASSERT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response dropped")
endmodule

// ===== rtl/ncl_cell.sv =====
// one cache entry: stores key, mac, time, and folds its entry into the scan token
// the token is registered here and reaches the upper neighbor in the next cycle
// depends on ncl_pkg
module ncl_cell #(
   parameter int IDX_W = 4,
   parameter logic [IDX_W-1:0] INDEX = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ncl_pkg::request_type  req,
   input  ncl_pkg::token_type    tok_in,
   output ncl_pkg::token_type    tok_out,
   output logic                  match,
   output logic [ncl_pkg::MAC_W-1:0] mac,
   input  logic                  wr_key,
   input  logic                  wr_mac,
   input  logic                  wr_time
);
   logic                        valid_ff;
   logic [ncl_pkg::KEY_W-1:0]   kh_ff, kl_ff;
   logic [ncl_pkg::MAC_W-1:0]   mac_ff;
   logic [ncl_pkg::TIME_W-1:0]  time_ff;
   ncl_pkg::token_type          fold_ff, fold_in;

   assign match   = valid_ff && kh_ff == req.key_high && kl_ff == req.key_low;
   assign mac     = mac_ff;
   assign tok_out = fold_ff;

   // fold this entry into the token from the lower neighbor
   always_comb begin
      fold_in = tok_in;
      if (!tok_in.free && !valid_ff) begin
         fold_in.free = 1'b1;
         fold_in.slot = 6'(INDEX);
      end else if (!tok_in.free && time_ff < tok_in.oldest) begin
         fold_in.old    = 1'b1;
         fold_in.oldest = time_ff;
         fold_in.slot   = 6'(INDEX);
      end
   end

   // hand the token to the upper neighbor
   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_key) begin
         valid_ff <= 1'b1;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (wr_key) begin
         kh_ff <= req.key_high;
         kl_ff <= req.key_low;
      end
      if (wr_mac) mac_ff <= req.mac;
      if (wr_time) time_ff <= req.now;
   end
endmodule
